// ===== hw/rtl/kars_pkg.sv =====
// shared types and constants of the key autorepeat scan block
`default_nettype none

package kars_pkg;

    localparam int KEY_WIDTH = 8;
    localparam int CFG_WIDTH = 15;
    localparam int CFG_IDX_WIDTH = 1;

    // lowest key code that takes part in the scan
    localparam logic [KEY_WIDTH-1:0] FIRST_KEY = 8'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_REPEAT_DELAY = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_REPEAT_INTERVAL = 1'b1;

    // reset values of the configuration registers
    localparam logic [CFG_WIDTH-1:0] DELAY_RESET = 15'd66;
    localparam logic [CFG_WIDTH-1:0] INTERVAL_RESET = 15'd4;

    // per-scan key flags carried with a word
    typedef struct packed {
        logic key_down;
        logic is_modifier;
        logic ctrl;
        logic shift;
        logic alt;
        logic caps;
    } key_flags_t;

    // table update decision
    typedef struct packed {
        logic wr_en;
        logic emit;
    } upd_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kars_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module kars_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kars_hold.sv =====
// per-key state update: press detection and hold counter with wrap
`default_nettype none

module kars_hold #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire kars_pkg::key_flags_t               flags,
    input  wire logic                               in_range,
    input  wire logic                               was_down,
    input  wire logic [COUNT_WIDTH-1:0]             cur_count,
    input  wire logic [kars_pkg::CFG_WIDTH-1:0]     delay,
    input  wire logic [kars_pkg::CFG_WIDTH-1:0]     interval,
    output kars_pkg::upd_ctl_t                      ctl,
    output logic                                    next_was_down,
    output logic      [COUNT_WIDTH-1:0]             next_count
);
    import kars_pkg::*;

    // wide enough for the counter and for delay + interval
    localparam int CW = ((COUNT_WIDTH > CFG_WIDTH + 1) ? COUNT_WIDTH : CFG_WIDTH + 1) + 1;

    logic [CW-1:0] delay_w;
    logic [CW-1:0] rate_w;
    logic [CW-1:0] limit_w;
    logic [CW-1:0] cur_w;
    logic [CW-1:0] cmax_w;
    logic [CW-1:0] nxt_w;

    assign delay_w = CW'(delay);
    // zero interval acts as one
    assign rate_w  = (interval == '0) ? CW'(1) : CW'(interval);
    assign limit_w = delay_w + rate_w;
    assign cur_w   = CW'(cur_count);
    assign cmax_w  = CW'({COUNT_WIDTH{1'b1}});

    always_comb begin
        ctl           = '0;
        next_was_down = 1'b1;
        next_count    = cur_count;
        nxt_w         = '0;
        priority if (!in_range) begin
            ctl.wr_en = 1'b0;
        end else if (!flags.key_down) begin
            ctl.wr_en     = 1'b1;
            next_was_down = 1'b0;
            next_count    = '0;
        end else if (flags.is_modifier) begin
            ctl.wr_en = 1'b1;
        end else if (!was_down) begin
            ctl.wr_en = 1'b1;
            ctl.emit  = 1'b1;
        end else if (cur_w >= limit_w) begin
            // wrap back just past the delay
            nxt_w      = delay_w + CW'(1);
            ctl.wr_en  = 1'b1;
            ctl.emit   = (nxt_w == delay_w) || (nxt_w == limit_w);
            next_count = nxt_w[COUNT_WIDTH-1:0];
        end else if (cur_w >= cmax_w) begin
            // saturated counter: no more repeats until release
            ctl.wr_en = 1'b1;
        end else begin
            nxt_w      = cur_w + CW'(1);
            ctl.wr_en  = 1'b1;
            ctl.emit   = (nxt_w == delay_w) || (nxt_w == limit_w);
            next_count = nxt_w[COUNT_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/key_autorepeat_scan_top.sv =====
// top level of the key autorepeat scan block
`default_nettype none

// Typematic repeat for a periodic key scan. Each input word presents one key
// with its pressed state, a modifier mark and the current modifier levels.
// A new press gives one output word at once; a key that stays held gives a
// word when its hold count reaches repeat_delay and then every
// repeat_interval scans. Released keys clear their state; modifier keys and
// codes below 8 or at or above KEY_COUNT give nothing. Throughput is one word
// per cycle: the per-key state (pressed bit and hold counter) sits in one
// ram with one read and one write port, read at accept and written back
// when the update stage moves; a forwarding register covers the same key
// arriving on consecutive cycles. The update stage feeds the output
// register behind m_valid and stalls only while that register holds a
// word that is not taken. Reset clears the whole table at once through
// per-key valid bits, so no clearing pass is needed. Configuration writes
// take effect at once and are meant for idle time.

module key_autorepeat_scan_top #(
    parameter int KEY_COUNT   = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [kars_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [kars_pkg::CFG_WIDTH-1:0]      cfg_data,
    // scan input
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [kars_pkg::KEY_WIDTH-1:0]      s_key_code,
    input  wire logic                                s_key_down,
    input  wire logic                                s_is_modifier,
    input  wire logic                                s_ctrl_held,
    input  wire logic                                s_shift_held,
    input  wire logic                                s_alt_held,
    input  wire logic                                s_caps_lock,
    // key events
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [kars_pkg::KEY_WIDTH-1:0]      m_key_out,
    output logic                                     m_level,
    output logic                                     m_ctrl_out,
    output logic                                     m_shift_out,
    output logic                                     m_alt_out
);
    import kars_pkg::*;

    localparam int IDX_W  = $clog2(KEY_COUNT);
    localparam int MEM_W  = COUNT_WIDTH + 1;

    // configuration registers
    logic [CFG_WIDTH-1:0] delay_reg;
    logic [CFG_WIDTH-1:0] interval_reg;

    // update stage registers
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [KEY_WIDTH-1:0] s1_key_reg;
    key_flags_t           s1_flags_reg;
    logic                 s1_range_reg;
    logic                 s1_vbit_reg;

    // forwarding of the last table write
    logic                 fwd_valid_reg;
    logic [IDX_W-1:0]     fwd_idx_reg;
    logic [MEM_W-1:0]     fwd_data_reg;

    // per-key valid bits, cleared by reset
    logic [KEY_COUNT-1:0] vld_reg;

    // output register
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [KEY_WIDTH-1:0] m_key_reg;
    logic                 m_level_reg;
    logic                 m_ctrl_reg;
    logic                 m_shift_reg;
    logic                 m_alt_reg;

    logic                 s_accept;
    logic                 s1_fire;
    logic                 in_range;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     wr_idx;
    logic                 fwd_hit;
    logic [MEM_W-1:0]     ram_rdata;
    logic [MEM_W-1:0]     cur_entry;
    logic [MEM_W-1:0]     wr_entry;
    logic                 ram_we;
    key_flags_t           in_flags;
    upd_ctl_t             ctl;
    logic                 next_was_down;
    logic [COUNT_WIDTH-1:0] next_count;

    // handshake: update stage moves unless a word waits in the output reg
    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;

    // keys below the first code or past the table are ignored
    assign in_range = (s_key_code >= FIRST_KEY)
                   && ({1'b0, s_key_code} < (KEY_WIDTH + 1)'(KEY_COUNT));
    assign rd_idx   = s_key_code[IDX_W-1:0];
    assign wr_idx   = s1_key_reg[IDX_W-1:0];

    assign in_flags.key_down    = s_key_down;
    assign in_flags.is_modifier = s_is_modifier;
    assign in_flags.ctrl        = s_ctrl_held;
    assign in_flags.shift       = s_shift_held;
    assign in_flags.alt         = s_alt_held;
    assign in_flags.caps        = s_caps_lock;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg    <= DELAY_RESET;
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_REPEAT_DELAY:    delay_reg    <= cfg_data;
                REG_REPEAT_INTERVAL: interval_reg <= cfg_data;
                default:             delay_reg    <= delay_reg;
            endcase
        end
    end

    // key state table: {was_down, hold_count}
    kars_ram #(
        .WIDTH(MEM_W),
        .DEPTH(KEY_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .re    (s_accept && in_range),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // update stage capture
    assign s1_valid_next = s_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_key_reg   <= s_key_code;
            s1_flags_reg <= in_flags;
            s1_range_reg <= in_range;
            s1_vbit_reg  <= in_range && vld_reg[rd_idx];
        end
    end

    // current entry: last write to the same key wins, untouched keys read zero
    assign fwd_hit   = fwd_valid_reg && (fwd_idx_reg == wr_idx);
    assign cur_entry = fwd_hit ? fwd_data_reg : (s1_vbit_reg ? ram_rdata : '0);

    kars_hold #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_hold (
        .flags         (s1_flags_reg),
        .in_range      (s1_range_reg),
        .was_down      (cur_entry[COUNT_WIDTH]),
        .cur_count     (cur_entry[COUNT_WIDTH-1:0]),
        .delay         (delay_reg),
        .interval      (interval_reg),
        .ctl           (ctl),
        .next_was_down (next_was_down),
        .next_count    (next_count)
    );

    assign ram_we   = s1_fire && ctl.wr_en;
    assign wr_entry = {next_was_down, next_count};

    // forwarding register and valid bits follow every table write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end else if (ram_we) begin
            fwd_valid_reg   <= 1'b1;
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            fwd_idx_reg  <= wr_idx;
            fwd_data_reg <= wr_entry;
        end
    end

    // output register
    assign m_valid_next = (s1_fire && ctl.emit) ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && ctl.emit) begin
            m_key_reg   <= s1_key_reg;
            m_level_reg <= s1_flags_reg.shift ^ s1_flags_reg.caps;
            m_ctrl_reg  <= s1_flags_reg.ctrl;
            m_shift_reg <= s1_flags_reg.shift;
            m_alt_reg   <= s1_flags_reg.alt;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_key_out   = m_key_reg;
    assign m_level     = m_level_reg;
    assign m_ctrl_out  = m_ctrl_reg;
    assign m_shift_out = m_shift_reg;
    assign m_alt_out   = m_alt_reg;

    // a written key reads as valid from then on
    a_vld_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> vld_reg[$past(wr_idx)])
        else $error("valid bit not set after table write");

    // a new output word comes from a pressed non-modifier key
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_flags_reg.key_down && !s1_flags_reg.is_modifier
                                     && s1_range_reg))
        else $error("event from released, modifier or ignored key");

    // events never carry key codes below the first scanned code
    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_key_reg >= FIRST_KEY))
        else $error("event with ignored key code");

endmodule

`default_nettype wire
